/* hdl/selective_repeat_receive_window_assert.svh */
//----------------------------------------------------------------------------
// selective repeat receive window assertion macros
// shared concurrent assertion forms, clocked on the block clock
//----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH

// same-cycle implication
`define SRRW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/srrw_pkg.sv */
//----------------------------------------------------------------------------
// srrw_pkg
// shared widths, codes and types of the selective repeat receive window
//----------------------------------------------------------------------------
package srrw_pkg;

   localparam int MAX_WINDOW_DEF = 64;

   localparam int SEQ_W     = 7;
   localparam int LEN_W     = 11;
   localparam int WIN_W     = 7;
   localparam int PKTS_W    = 7;
   localparam int BYTES_W   = 17;
   localparam int STATUS_W  = 2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd60;

   // register index, taken from the word address bit
   localparam logic REG_WINDOW = 1'b0;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_RELEASED,
      STATUS_BUFFERED,
      STATUS_DUPLICATE,
      STATUS_OUTSIDE
   } srrw_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_WALK,
      S_DONE
   } srrw_state_type;

   typedef struct packed {
      logic load;
      logic start_walk;
      logic mark;
      logic drop;
      logic step;
      logic finish;
      logic emit;
   } srrw_cmd_type;

   typedef struct packed {
      logic at_expected;
      logic outside;
      logic walk_more;
      logic out_free;
   } srrw_stat_type;

endpackage

/* hdl/srrw_ctrl.sv */
//----------------------------------------------------------------------------
// srrw_ctrl
// sequencer: evaluate header, walk the buffered run, hand off the result
//----------------------------------------------------------------------------
module srrw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  srrw_pkg::srrw_stat_type stat,
   output srrw_pkg::srrw_cmd_type  cmd
);
   import srrw_pkg::*;

   srrw_state_type state_ff;
   srrw_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.at_expected) begin
               state_in = S_WALK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WALK: begin
            if (!stat.walk_more) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_EVAL: begin
            priority if (stat.at_expected) begin
               cmd.start_walk = 1'b1;
            end else if (stat.outside) begin
               cmd.drop = 1'b1;
            end else begin
               cmd.mark = 1'b1;
            end
         end
         S_WALK: begin
            cmd.step   = stat.walk_more;
            cmd.finish = !stat.walk_more;
         end
         S_DONE: begin
            cmd.emit = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* hdl/srrw_datapath.sv */
//----------------------------------------------------------------------------
// srrw_datapath
// window state, received map, length store, byte sum and result register
//----------------------------------------------------------------------------
`include "selective_repeat_receive_window_assert.svh"

module srrw_datapath #(
   parameter int MAX_WINDOW = srrw_pkg::MAX_WINDOW_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  srrw_pkg::srrw_cmd_type        cmd,
   output srrw_pkg::srrw_stat_type       stat,
   input  logic                          cfg_wr,
   input  logic [srrw_pkg::WIN_W-1:0]    cfg_data,
   output logic [srrw_pkg::WIN_W-1:0]    window_size,
   input  logic [srrw_pkg::SEQ_W-1:0]    seq_num,
   input  logic [srrw_pkg::LEN_W-1:0]    payload_len,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output srrw_pkg::srrw_status_type     status,
   output logic [srrw_pkg::SEQ_W-1:0]    cum_ack,
   output logic [srrw_pkg::SEQ_W-1:0]    sel_ack,
   output logic [srrw_pkg::PKTS_W-1:0]   released_packets,
   output logic [srrw_pkg::BYTES_W-1:0]  released_bytes
);
   import srrw_pkg::*;

   localparam int MAP_DEPTH = 2 * MAX_WINDOW;
   localparam int IDX_W     = $clog2(MAP_DEPTH);
   localparam int SPACE_W   = WIN_W + 1;
   localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_WINDOW);

   logic [WIN_W-1:0]    win_ff;
   logic [SEQ_W-1:0]    ne_ff;
   logic [MAP_DEPTH-1:0] map_ff;
   logic [SEQ_W-1:0]    seq_ff;
   logic [LEN_W-1:0]    len_ff;
   srrw_status_type     status_ff;
   logic [SEQ_W-1:0]    sel_ff;
   logic [PKTS_W-1:0]   pkts_ff;
   logic [BYTES_W-1:0]  bytes_ff;
   logic [SEQ_W-1:0]    p_ff;
   logic                pend_ff;
   logic [LEN_W-1:0]    mem_q_ff;
   logic [LEN_W-1:0]    len_mem_ff [MAP_DEPTH];

   logic                rsp_valid_ff;
   srrw_status_type     out_status_ff;
   logic [SEQ_W-1:0]    out_cum_ff;
   logic [SEQ_W-1:0]    out_sel_ff;
   logic [PKTS_W-1:0]   out_pkts_ff;
   logic [BYTES_W-1:0]  out_bytes_ff;

   logic [WIN_W-1:0]    eff_win;
   logic [SPACE_W-1:0]  space;
   logic [SPACE_W-1:0]  diff;
   logic [SPACE_W-1:0]  circ_dist;
   logic                in_space;
   logic                at_expected;
   logic                in_window;
   logic                seq_seen;
   logic [SEQ_W-1:0]    p_next;
   logic [SEQ_W-1:0]    cum;
   logic [BYTES_W-1:0]  bytes_acc;
   logic [IDX_W-1:0]    seq_idx;
   logic [IDX_W-1:0]    p_idx;
   logic [IDX_W-1:0]    ne_idx;

   function automatic logic [SEQ_W-1:0] p_next_from_ne(input logic [SEQ_W-1:0]   ne,
                                                      input logic [SPACE_W-1:0] spc);
      logic [SPACE_W-1:0] nxt;
      nxt = {1'b0, ne} + SPACE_W'(1);
      return (nxt == spc) ? '0 : nxt[SEQ_W-1:0];
   endfunction

   // effective window, clamped to 1..MAX_WINDOW
   always_comb begin
      priority if (win_ff == '0) begin
         eff_win = WIN_W'(1);
      end else if (win_ff > WIN_MAX) begin
         eff_win = WIN_MAX;
      end else begin
         eff_win = win_ff;
      end
   end

   assign space    = {eff_win, 1'b0};
   assign seq_idx  = seq_ff[IDX_W-1:0];
   assign p_idx    = p_ff[IDX_W-1:0];
   assign ne_idx   = ne_ff[IDX_W-1:0];

   // circular distance from the expected number
   assign in_space    = {1'b0, seq_ff} < space;
   assign diff        = {1'b0, seq_ff} - {1'b0, ne_ff};
   assign circ_dist   = (seq_ff >= ne_ff) ? diff : diff + space;
   assign at_expected = in_space && (seq_ff == ne_ff);
   assign in_window   = in_space && (circ_dist < {1'b0, eff_win});
   assign seq_seen    = map_ff[seq_idx];

   assign p_next    = ({1'b0, p_ff} + SPACE_W'(1) == space) ? '0 : p_ff + SEQ_W'(1);
   assign cum       = (ne_ff == '0) ? SEQ_W'(space - SPACE_W'(1)) : ne_ff - SEQ_W'(1);
   assign bytes_acc = bytes_ff + (pend_ff ? BYTES_W'(mem_q_ff) : '0);

   assign stat.at_expected = at_expected;
   assign stat.outside     = !at_expected && !in_window;
   assign stat.walk_more   = map_ff[p_idx] && (pkts_ff < eff_win);
   assign stat.out_free    = !rsp_valid_ff || rsp_tready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= WINDOW_RESET;
         ne_ff        <= '0;
         map_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (cfg_wr) begin
            win_ff <= cfg_data;
            ne_ff  <= '0;
            map_ff <= '0;
         end
         if (cmd.mark && !seq_seen) begin
            map_ff[seq_idx] <= 1'b1;
         end
         if (cmd.step) begin
            map_ff[p_idx] <= 1'b0;
         end
         if (cmd.finish) begin
            ne_ff <= p_ff;
         end
         if (cmd.start_walk) begin
            pend_ff <= 1'b0;
         end else if (cmd.step || cmd.finish) begin
            pend_ff <= cmd.step;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item payload and walk accumulators
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         seq_ff <= seq_num;
         len_ff <= payload_len;
      end
      if (cmd.start_walk) begin
         status_ff <= STATUS_RELEASED;
         pkts_ff   <= PKTS_W'(1);
         bytes_ff  <= BYTES_W'(len_ff);
         p_ff      <= p_next_from_ne(ne_ff, space);
      end
      if (cmd.mark) begin
         status_ff <= seq_seen ? STATUS_DUPLICATE : STATUS_BUFFERED;
         sel_ff    <= seq_ff;
         pkts_ff   <= '0;
         bytes_ff  <= '0;
      end
      if (cmd.drop) begin
         status_ff <= STATUS_OUTSIDE;
         pkts_ff   <= '0;
         bytes_ff  <= '0;
      end
      if (cmd.step) begin
         p_ff     <= p_next;
         pkts_ff  <= pkts_ff + PKTS_W'(1);
         bytes_ff <= bytes_acc;
      end
      if (cmd.finish) begin
         bytes_ff <= bytes_acc;
      end
   end

   // length store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.mark && !seq_seen) begin
         len_mem_ff[seq_idx] <= len_ff;
      end
      if (cmd.step) begin
         mem_q_ff <= len_mem_ff[p_idx];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_status_ff <= status_ff;
         out_cum_ff    <= cum;
         out_sel_ff    <= (status_ff == STATUS_BUFFERED || status_ff == STATUS_DUPLICATE)
                          ? sel_ff : cum;
         out_pkts_ff   <= pkts_ff;
         out_bytes_ff  <= bytes_ff;
      end
   end

   assign window_size      = win_ff;
   assign rsp_tvalid       = rsp_valid_ff;
   assign status           = out_status_ff;
   assign cum_ack          = out_cum_ff;
   assign sel_ack          = out_sel_ff;
   assign released_packets = out_pkts_ff;
   assign released_bytes   = out_bytes_ff;

   `SRRW_ASSERT_IMPL(a_expected_slot_clear, clock, reset, 1'b1, !map_ff[ne_idx],
      "slot of the expected number is marked buffered")
   `SRRW_ASSERT_IMPL(a_release_counts, clock, reset,
      rsp_valid_ff && out_status_ff == STATUS_RELEASED, out_pkts_ff != '0,
      "release beat carries no packet")
   `SRRW_ASSERT_IMPL(a_no_release_counts, clock, reset,
      rsp_valid_ff && out_status_ff != STATUS_RELEASED,
      out_pkts_ff == '0 && out_bytes_ff == '0,
      "non-release beat carries released packets or bytes")
   `SRRW_ASSERT_IMPL(a_sel_differs, clock, reset,
      rsp_valid_ff && (out_status_ff == STATUS_BUFFERED || out_status_ff == STATUS_DUPLICATE),
      out_sel_ff != out_cum_ff,
      "selective ack of a buffered packet equals the cumulative ack")
   `SRRW_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid_ff,
      "result load did not raise the result valid")

endmodule

/* hdl/selective_repeat_receive_window.sv */
//----------------------------------------------------------------------------
// selective_repeat_receive_window
// selective-repeat receiver window: header in, release/ack result out
//----------------------------------------------------------------------------
// usage
//   req_ channel: one packet header per beat (sequence number, payload length)
//   rsp_ channel: one result beat per header (status, cumulative ack,
//     selective ack, released packet count, released byte count)
//   csr_ port: register 0 at byte address 0 is window_size; writing it
//     restarts the receive session (expected number 0, received map empty);
//     write it only while no header is in flight
// timing
//   one header at a time; req_tready is high only while the sequencer idles
//   buffered, duplicate or dropped header: idle, evaluate, then done, where the
//     result is loaded into the output register once the slot is free
//   in-order header releasing k buffered followers: idle, evaluate, walk, done;
//     the run walk reads the length store one slot per cycle
// reset
//   window_size returns to 60, expected number to 0, received map cleared;
//   no clearing pass is needed, the map is held in flip-flops
// back-pressure
//   a result waits in the output register while rsp_tready is low; the next
//   header is accepted and worked on, and its result waits for the slot
//----------------------------------------------------------------------------
module selective_repeat_receive_window #(
   parameter int MAX_WINDOW = srrw_pkg::MAX_WINDOW_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // [6:0] seq_num, [17:7] payload_len, [23:18] zero
   input  logic [srrw_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] status, [8:2] cum_ack, [15:9] sel_ack, [22:16] released_packets,
   // [39:23] released_bytes
   output logic [srrw_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [srrw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [srrw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [srrw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import srrw_pkg::*;

   srrw_cmd_type         cmd;
   srrw_stat_type        stat;
   logic                 cfg_wr;
   logic [WIN_W-1:0]     window_size;
   srrw_status_type      status;
   logic [SEQ_W-1:0]     cum_ack;
   logic [SEQ_W-1:0]     sel_ack;
   logic [PKTS_W-1:0]    released_packets;
   logic [BYTES_W-1:0]   released_bytes;

   // register decode on the word address bit, byte offset ignored
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_WINDOW);
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW)
                       ? {{(CSR_DATA_W-WIN_W){1'b0}}, window_size} : '0;

   srrw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   srrw_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .cfg_wr           (cfg_wr),
      .cfg_data         (csr_pwdata[WIN_W-1:0]),
      .window_size      (window_size),
      .seq_num          (req_tdata[SEQ_W-1:0]),
      .payload_len      (req_tdata[SEQ_W+LEN_W-1:SEQ_W]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .status           (status),
      .cum_ack          (cum_ack),
      .sel_ack          (sel_ack),
      .released_packets (released_packets),
      .released_bytes   (released_bytes)
   );

   // result fields packed from the lowest bit up
   assign rsp_tdata = {released_bytes, released_packets, sel_ack, cum_ack, status};

endmodule
